>>> hw/rtl/ttcs_pkg.sv
// Shared types and constants for the text terminal cursor/scroll unit.
// No dependencies.
`default_nettype none

package ttcs_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_PUT   = 2'd0;
   localparam opcode_type OP_READ  = 2'd1;
   localparam opcode_type OP_CLEAR = 2'd2;

   localparam logic [7:0] CH_BELL  = 8'h07;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BLANK = 8'h20;

   localparam logic [7:0]  ATTR_RESET = 8'h07;
   localparam logic [15:0] CELL_RESET = 16'h0720;

   localparam logic [3:0] TAB_STOP = 4'd8;

   // byte address of the color attribute register
   localparam logic [2:0] CSR_COLOR_ADDR = 3'd0;

endpackage

`default_nettype wire

>>> hw/rtl/text_terminal_cursor_scroll_unit.sv
// Text terminal: ROWS x COLUMNS cell store in one synchronous RAM, cursor, scroll.
// Rows live in a circular buffer; scroll moves the top pointer and blanks one row.
// Put writes a printable character, or blank cells up to the tab stop, and blanks a row on scroll;
//   read splits the address by repeated subtraction; clear blanks every cell.
// Throughput: one transfer at a time; the single RAM write port sets fill cost.
// Reset: cursor homed, attribute 0x07, then a pass over every cell blanks the
//   RAM with 0x0720 while req_ready stays low (CSR writes are taken meanwhile).
`default_nettype none

module text_terminal_cursor_scroll_unit
   import ttcs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic [10:0] req_cell_address,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_cell_value,
   output logic [4:0]       rsp_cursor_row,
   output logic [6:0]       rsp_cursor_column,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int A_W   = $clog2(CELLS);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int CNT_W = $clog2(CELLS + 1);
   localparam int CMP_W = (A_W > 11) ? A_W : 11;

   localparam logic [A_W-1:0]   COLS_A   = A_W'(COLUMNS);
   localparam logic [COL_W:0]   COLS_C   = (COL_W + 1)'(COLUMNS);
   localparam logic [ROW_W:0]   ROWS_R   = (ROW_W + 1)'(ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [10:0]      COLS_11  = 11'(COLUMNS);
   localparam logic [CNT_W-1:0] CELLS_N  = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0] COLS_N   = CNT_W'(COLUMNS);

   // physical cell address of a logical row/column under the current top row
   function automatic logic [A_W-1:0] phys_addr(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
      logic [ROW_W:0] prow;
      prow = (ROW_W + 1)'(top) + (ROW_W + 1)'(row);
      if (prow >= ROWS_R) begin
         prow = prow - ROWS_R;
      end
      return A_W'(prow) * COLS_A + A_W'(col);
   endfunction

   state_type        state_ff, state_in;
   logic             init_ff, init_in;
   logic [7:0]       attr_ff, attr_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] top_ff, top_in;

   logic [A_W-1:0]   fill_addr_ff, fill_addr_in;
   logic [CNT_W-1:0] fill_left_ff, fill_left_in;
   logic [15:0]      fill_data_ff, fill_data_in;
   logic             scroll_pend_ff, scroll_pend_in;
   logic [A_W-1:0]   scroll_addr_ff, scroll_addr_in;

   logic [10:0]      rem_ff, rem_in;
   logic [ROW_W-1:0] quot_ff, quot_in;
   logic [15:0]      value_ff, value_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_value_ff, rsp_value_in;
   logic [4:0]       rsp_row_ff, rsp_row_in;
   logic [6:0]       rsp_col_ff, rsp_col_in;

   logic [15:0]      mem [CELLS];
   logic [15:0]      rd_data_ff;
   logic [A_W-1:0]   rd_addr;
   logic             mem_we;

   // put-character plan, from the cursor and the incoming byte
   logic             is_tab, is_nl, is_bell, is_print;
   logic [3:0]       tab_w, tab_n, first_cnt;
   logic [COL_W:0]   room, col_adv;
   logic [ROW_W:0]   row_adv;
   logic             scroll;
   logic [A_W-1:0]   cursor_addr, top_addr;
   logic [ROW_W-1:0] top_next;
   logic [15:0]      blank_cell;
   logic             out_free;

   always_comb begin
      is_bell  = (req_char_byte == CH_BELL);
      is_tab   = (req_char_byte == CH_TAB);
      is_nl    = (req_char_byte == CH_LF) || (req_char_byte == CH_CR);
      is_print = !req_char_byte[7] && (req_char_byte[6:5] != 2'b00);
      tab_w    = TAB_STOP - {1'b0, cur_col_ff[2:0]};
      room     = COLS_C - (COL_W + 1)'(cur_col_ff);
      tab_n    = ((COL_W + 1)'(tab_w) > room) ? 4'(room) : tab_w;
      row_adv  = (ROW_W + 1)'(cur_row_ff);
      if (is_bell) begin
         col_adv = (COL_W + 1)'(cur_col_ff);
      end else if (is_tab) begin
         col_adv = (COL_W + 1)'(cur_col_ff) + (COL_W + 1)'(tab_w);
      end else if (is_nl) begin
         col_adv = '0;
         row_adv = row_adv + 1'b1;
      end else begin
         col_adv = (COL_W + 1)'(cur_col_ff) + 1'b1;
      end
      // line wrap
      if (col_adv >= COLS_C) begin
         col_adv = '0;
         row_adv = row_adv + 1'b1;
      end
      scroll = (row_adv >= ROWS_R);
      if (is_tab) begin
         first_cnt = tab_n;
      end else if (is_print) begin
         first_cnt = 4'd1;
      end else begin
         first_cnt = 4'd0;
      end
      cursor_addr = phys_addr(top_ff, cur_row_ff, cur_col_ff);
      top_addr    = A_W'(top_ff) * COLS_A;
      top_next    = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
      blank_cell  = {attr_ff, CH_BLANK};
   end

   always_comb begin
      state_in       = state_ff;
      init_in        = init_ff;
      attr_in        = attr_ff;
      cur_row_in     = cur_row_ff;
      cur_col_in     = cur_col_ff;
      top_in         = top_ff;
      fill_addr_in   = fill_addr_ff;
      fill_left_in   = fill_left_ff;
      fill_data_in   = fill_data_ff;
      scroll_pend_in = scroll_pend_ff;
      scroll_addr_in = scroll_addr_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      value_in       = value_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;
      mem_we         = 1'b0;
      rd_addr        = phys_addr(top_ff, quot_ff, rem_ff[COL_W-1:0]);
      req_ready      = (state_ff == ST_IDLE);
      out_free       = !rsp_valid_ff || rsp_ready;

      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_COLOR_ADDR)) begin
         attr_in = csr_pwdata[7:0];
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = '0;
               case (req_opcode)
                  OP_PUT: begin
                     cur_col_in     = scroll ? '0 : COL_W'(col_adv);
                     cur_row_in     = scroll ? LAST_ROW : ROW_W'(row_adv);
                     scroll_pend_in = scroll;
                     scroll_addr_in = top_addr;
                     if (scroll) begin
                        top_in = top_next;
                     end
                     if (first_cnt != 4'd0) begin
                        fill_addr_in = cursor_addr;
                        fill_left_in = CNT_W'(first_cnt);
                        fill_data_in = is_tab ? blank_cell : {attr_ff, req_char_byte};
                        state_in     = ST_FILL;
                     end else if (scroll) begin
                        fill_addr_in   = top_addr;
                        fill_left_in   = COLS_N;
                        fill_data_in   = blank_cell;
                        scroll_pend_in = 1'b0;
                        state_in       = ST_FILL;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_READ: begin
                     if (CMP_W'(req_cell_address) < CMP_W'(CELLS)) begin
                        rem_in   = req_cell_address;
                        quot_in  = '0;
                        state_in = ST_DIVIDE;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_CLEAR: begin
                     cur_row_in     = '0;
                     cur_col_in     = '0;
                     top_in         = '0;
                     fill_addr_in   = '0;
                     fill_left_in   = CELLS_N;
                     fill_data_in   = blank_cell;
                     scroll_pend_in = 1'b0;
                     state_in       = ST_FILL;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            // split the linear address into row and column, one row per cycle
            if (rem_ff >= COLS_11) begin
               rem_in  = rem_ff - COLS_11;
               quot_in = quot_ff + 1'b1;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            value_in = rd_data_ff;
            state_in = ST_DONE;
         end
         ST_FILL: begin
            mem_we       = 1'b1;
            fill_addr_in = fill_addr_ff + 1'b1;
            fill_left_in = fill_left_ff - 1'b1;
            if (fill_left_ff == CNT_W'(1)) begin
               if (scroll_pend_ff) begin
                  fill_addr_in   = scroll_addr_ff;
                  fill_left_in   = COLS_N;
                  fill_data_in   = blank_cell;
                  scroll_pend_in = 1'b0;
               end else if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_row_in   = 5'(cur_row_ff);
               rsp_col_in   = 7'(cur_col_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_FILL;
         init_ff        <= 1'b1;
         attr_ff        <= ATTR_RESET;
         cur_row_ff     <= '0;
         cur_col_ff     <= '0;
         top_ff         <= '0;
         fill_addr_ff   <= '0;
         fill_left_ff   <= CELLS_N;
         fill_data_ff   <= CELL_RESET;
         scroll_pend_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         init_ff        <= init_in;
         attr_ff        <= attr_in;
         cur_row_ff     <= cur_row_in;
         cur_col_ff     <= cur_col_in;
         top_ff         <= top_in;
         fill_addr_ff   <= fill_addr_in;
         fill_left_ff   <= fill_left_in;
         fill_data_ff   <= fill_data_in;
         scroll_pend_ff <= scroll_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      scroll_addr_ff <= scroll_addr_in;
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      value_ff       <= value_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
   end

   // cell RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_addr_ff] <= fill_data_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_value_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_COLOR_ADDR) ? {24'd0, attr_ff} : 32'd0;

endmodule

`default_nettype wire
